FILE: rtl/sqke_pkg.sv
// ----------------------------------------------------------------------------
// sqke_pkg
// Shared types and codes for the keyed stack/queue list: operation codes,
// result status codes and the stored record layout.
// ----------------------------------------------------------------------------
package sqke_pkg;

  // field widths fixed by the record format
  localparam int ID_W     = 32;
  localparam int PRICE_W  = 32;
  localparam int HANDLE_W = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_EXTRACT    = 2'd3
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // one stored record
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PRICE_W-1:0]  price_bits;
    logic [HANDLE_W-1:0] shape_handle;
  } rec_t;

endpackage

FILE: rtl/stack_queue_keyed_extract.sv
// ----------------------------------------------------------------------------
// stack_queue_keyed_extract
// Bounded ordered list of records with push front, push back, pop front and
// extract of the first record whose id matches a key.
// ----------------------------------------------------------------------------
//  channel  ports                                   transfer
//  input    start/busy, in_opcode, in_item_*        start && !busy
//  result   out_valid, out_id, out_price_bits,      out_valid, one cycle
//           out_shape_handle, out_found, out_status
//
//  inserts, and pop or extract on an empty list, strobe the result on the
//  cycle after the transfer and busy stays low.
//  pop front makes one registered memory read; busy is high in S_POP.
//  extract walks the list one entry per cycle through the single memory read
//  port and closes the gap one record per cycle behind a match: busy stays
//  high until the last entry is handled and the result strobes after it,
//  found or not.
//  synchronous reset empties the list; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module stack_queue_keyed_extract #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_opcode,
  input  logic signed [31:0]   in_item_id,
  input  logic [31:0]          in_item_price_bits,
  input  logic [15:0]          in_item_shape_handle,
  output logic                 out_valid,
  output logic signed [31:0]   out_id,
  output logic [31:0]          out_price_bits,
  output logic [15:0]          out_shape_handle,
  output logic                 out_found,
  output logic [1:0]           out_status
);

  localparam int AW = $clog2(LIST_DEPTH);

  logic                        mem_wr_en;
  logic [AW-1:0]               mem_wr_addr;
  sqke_pkg::rec_t              mem_wr_data;
  logic                        mem_rd_en;
  logic [AW-1:0]               mem_rd_addr;
  logic [sqke_pkg::ID_W-1:0]   mem_key;
  sqke_pkg::rec_t              mem_rd_data;
  logic                        mem_id_match;
  sqke_pkg::rec_t              res_rec;
  sqke_pkg::status_t           res_status;

  // sequencer
  sqke_seq #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_item_id           (in_item_id),
    .in_item_price_bits   (in_item_price_bits),
    .in_item_shape_handle (in_item_shape_handle),
    .out_valid            (out_valid),
    .out_rec              (res_rec),
    .out_found            (out_found),
    .out_status           (res_status),
    .mem_wr_en            (mem_wr_en),
    .mem_wr_addr          (mem_wr_addr),
    .mem_wr_data          (mem_wr_data),
    .mem_rd_en            (mem_rd_en),
    .mem_rd_addr          (mem_rd_addr),
    .mem_key              (mem_key),
    .mem_rd_data          (mem_rd_data),
    .mem_id_match         (mem_id_match)
  );

  // record store and key compare
  sqke_store #(
    .DEPTH (LIST_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .key      (mem_key),
    .rd_data  (mem_rd_data),
    .id_match (mem_id_match)
  );

  // result fields
  assign out_id           = res_rec.id;
  assign out_price_bits   = res_rec.price_bits;
  assign out_shape_handle = res_rec.shape_handle;
  assign out_status       = res_status;

endmodule

FILE: rtl/sqke_store.sv
// ----------------------------------------------------------------------------
// sqke_store
// Record memory with one write port and one registered read port, plus the
// shared id comparator that checks the read record against the search key.
// ----------------------------------------------------------------------------
module sqke_store #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  sqke_pkg::rec_t             wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic [sqke_pkg::ID_W-1:0]  key,
  output sqke_pkg::rec_t             rd_data,
  output logic                       id_match
);

  sqke_pkg::rec_t mem [DEPTH];
  sqke_pkg::rec_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

  // shared key compare on the read record, all 32 bits
  assign id_match = (rd_data_r.id == key);

endmodule

FILE: rtl/sqke_seq.sv
// ----------------------------------------------------------------------------
// sqke_seq
// Sequencer for the keyed list: head and count bookkeeping, the one-entry-
// per-cycle scan and gap-closing shift, and the result registers.
// ----------------------------------------------------------------------------
module sqke_seq #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_opcode,
  input  logic [sqke_pkg::ID_W-1:0]        in_item_id,
  input  logic [sqke_pkg::PRICE_W-1:0]     in_item_price_bits,
  input  logic [sqke_pkg::HANDLE_W-1:0]    in_item_shape_handle,
  output logic                             out_valid,
  output sqke_pkg::rec_t                   out_rec,
  output logic                             out_found,
  output sqke_pkg::status_t                out_status,
  // memory side
  output logic                             mem_wr_en,
  output logic [$clog2(LIST_DEPTH)-1:0]    mem_wr_addr,
  output sqke_pkg::rec_t                   mem_wr_data,
  output logic                             mem_rd_en,
  output logic [$clog2(LIST_DEPTH)-1:0]    mem_rd_addr,
  output logic [sqke_pkg::ID_W-1:0]        mem_key,
  input  sqke_pkg::rec_t                   mem_rd_data,
  input  logic                             mem_id_match
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(LIST_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(LIST_DEPTH);
  localparam logic [SW-1:0] WRAP_SUM  = SW'(LIST_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t                     state_r;
  logic [AW-1:0]              head_r;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              k_r;
  logic [AW-1:0]              rd_ptr_r;
  logic [AW-1:0]              wr_ptr_r;
  logic [sqke_pkg::ID_W-1:0]  key_r;
  logic                       out_valid_r;
  sqke_pkg::rec_t             out_rec_r;
  logic                       out_found_r;
  sqke_pkg::status_t          out_status_r;

  logic                       accept;
  logic                       is_full;
  logic                       is_empty;
  logic [CW-1:0]              k_inc;
  logic                       more;
  logic [AW-1:0]              head_dec;
  logic [AW-1:0]              head_inc;
  logic [AW-1:0]              rd_ptr_inc;
  logic [SW-1:0]              tail_sum;
  logic [AW-1:0]              tail_slot;
  sqke_pkg::rec_t             in_rec;

  // circular slot helpers
  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_SLOT : p - AW'(1);
  endfunction

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);
  assign k_inc    = k_r + CW'(1);
  assign more     = (k_inc < count_r);

  assign head_dec   = slot_dec(head_r);
  assign head_inc   = slot_inc(head_r);
  assign rd_ptr_inc = slot_inc(rd_ptr_r);

  // tail slot: head plus count, wrapped once
  assign tail_sum  = {1'b0, head_r} + SW'(count_r);
  assign tail_slot = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : AW'(tail_sum);

  assign in_rec.id           = in_item_id;
  assign in_rec.price_bits   = in_item_price_bits;
  assign in_rec.shape_handle = in_item_shape_handle;

  // memory port steering
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_ptr_r;
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_ptr_inc;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == sqke_pkg::OP_PUSH_FRONT || in_opcode == sqke_pkg::OP_PUSH_BACK) begin
            mem_wr_en   = !is_full;
            mem_wr_addr = (in_opcode == sqke_pkg::OP_PUSH_FRONT) ? head_dec : tail_slot;
            mem_wr_data = in_rec;
          end else begin
            mem_rd_en   = !is_empty;
            mem_rd_addr = head_r;
          end
        end
      end
      S_POP: begin
      end
      S_SCAN: begin
        mem_rd_en = more;
      end
      S_SHIFT: begin
        // move the record just read one place toward the head
        mem_wr_en = 1'b1;
        mem_rd_en = more;
      end
      default: begin
      end
    endcase
  end

  assign mem_key = key_r;

  // sequencer state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      k_r         <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_r    <= in_item_id;
            rd_ptr_r <= head_r;
            k_r      <= '0;
            if (in_opcode == sqke_pkg::OP_PUSH_FRONT || in_opcode == sqke_pkg::OP_PUSH_BACK) begin
              // insert completes in the accept cycle
              out_valid_r  <= 1'b1;
              out_rec_r    <= '0;
              out_found_r  <= 1'b0;
              if (is_full) begin
                out_status_r <= sqke_pkg::ST_FULL;
              end else begin
                out_status_r <= sqke_pkg::ST_OK;
                count_r      <= count_r + CW'(1);
                if (in_opcode == sqke_pkg::OP_PUSH_FRONT) begin
                  head_r <= head_dec;
                end
              end
            end else if (is_empty) begin
              out_valid_r  <= 1'b1;
              out_rec_r    <= '0;
              out_found_r  <= 1'b0;
              out_status_r <= sqke_pkg::ST_EMPTY;
            end else if (in_opcode == sqke_pkg::OP_POP_FRONT) begin
              state_r <= S_POP;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_POP: begin
          out_valid_r  <= 1'b1;
          out_rec_r    <= mem_rd_data;
          out_found_r  <= 1'b1;
          out_status_r <= sqke_pkg::ST_OK;
          head_r       <= head_inc;
          count_r      <= count_r - CW'(1);
          state_r      <= S_IDLE;
        end
        S_SCAN: begin
          if (mem_id_match) begin
            // first match from the head: hold it, then close the gap
            out_rec_r    <= mem_rd_data;
            out_found_r  <= 1'b1;
            out_status_r <= sqke_pkg::ST_OK;
            wr_ptr_r     <= rd_ptr_r;
            if (more) begin
              rd_ptr_r <= rd_ptr_inc;
              k_r      <= k_inc;
              state_r  <= S_SHIFT;
            end else begin
              count_r     <= count_r - CW'(1);
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else if (more) begin
            rd_ptr_r <= rd_ptr_inc;
            k_r      <= k_inc;
          end else begin
            out_valid_r  <= 1'b1;
            out_rec_r    <= '0;
            out_found_r  <= 1'b0;
            out_status_r <= sqke_pkg::ST_NOT_FOUND;
            state_r      <= S_IDLE;
          end
        end
        S_SHIFT: begin
          wr_ptr_r <= rd_ptr_r;
          if (more) begin
            rd_ptr_r <= rd_ptr_inc;
            k_r      <= k_inc;
          end else begin
            count_r     <= count_r - CW'(1);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rec    = out_rec_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  // a result is only presented once the sequencer is back to idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer busy");

  // a returned record always carries ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == sqke_pkg::ST_OK))
    else $error("found record with non-ok status");

  // when nothing is returned the payload is zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_rec_r == '0))
    else $error("nonzero payload without a found record");

  // occupancy never exceeds the list depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above list depth");

  // inserts finish in the accept cycle
  a_push_one: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == sqke_pkg::OP_PUSH_FRONT ||
                in_opcode == sqke_pkg::OP_PUSH_BACK)) |=> (out_valid_r && !busy))
    else $error("insert did not complete in one cycle");
`endif

endmodule
